// ===== hdl/wmf_pkg.sv =====
// Shared types and constants for the window median filter.
// No dependencies; used by every other file of the block.
package wmf_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 13;  // input row index, runs R rows past the frame
   localparam int OROW_W     = 12;
   localparam int WIDTH_MIN  = 8;
   localparam int HEIGHT_MIN = 8;

   localparam logic [9:0]  WIDTH_RESET  = 10'd320;
   localparam logic [11:0] HEIGHT_RESET = 12'd320;
   localparam logic [1:0]  RADIUS_RESET = 2'd1;

   // register indexes, byte address 4*index
   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_KERNEL_RADIUS = 2'd2;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic      valid;
      logic      last;
      logic      interior;
      pixel_type center;
   } cell_ctl_type;

endpackage

// ===== hdl/wmf_row_store.sv =====
// Line stores: one memory per buffered row, all read at the same column.
// Depends on wmf_pkg for the pixel type.
module wmf_row_store #(
   parameter int LINES  = 6,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int LINE_W = 3
) (
   input  logic                             clock,
   input  logic                             access,
   input  logic [LINE_W-1:0]                wr_line,
   input  logic [ADDR_W-1:0]                addr,
   input  wmf_pkg::pixel_type               wr_data,
   output wmf_pkg::pixel_type [LINES-1:0]   rd_data
);

   wmf_pkg::pixel_type [LINES-1:0] rd_data_ff;

   for (genvar l = 0; l < LINES; l++) begin : g_line
      wmf_pkg::pixel_type mem [DEPTH];

      // read returns the old entry when the same line is written
      always_ff @(posedge clock) begin
         if (access) begin
            rd_data_ff[l] <= mem[addr];
            if (wr_line == LINE_W'(l)) begin
               mem[addr] <= wr_data;
            end
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/wmf_bit_cell.sv =====
// One cell of the median chain: settles one bit of the rank-k value, MSB first.
// Depends on wmf_pkg for the pixel and control types.
module wmf_bit_cell #(
   parameter int CELLS  = 49,
   parameter int RANK_W = 6,
   parameter int BIT    = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  wmf_pkg::cell_ctl_type             ctl_in,
   input  wmf_pkg::pixel_type [CELLS-1:0]    vals_in,
   input  logic [CELLS-1:0]                  mask_in,
   input  logic [RANK_W-1:0]                 rank_in,
   input  wmf_pkg::pixel_type                prefix_in,
   output wmf_pkg::cell_ctl_type             ctl_out,
   output wmf_pkg::pixel_type [CELLS-1:0]    vals_out,
   output logic [CELLS-1:0]                  mask_out,
   output logic [RANK_W-1:0]                 rank_out,
   output wmf_pkg::pixel_type                prefix_out
);

   localparam int CNT_W = $clog2(CELLS + 1);

   logic [CELLS-1:0]   zeros;
   logic [CNT_W-1:0]   cnt;
   logic               take_one;
   logic [CELLS-1:0]   mask_in_n;
   logic [RANK_W-1:0]  rank_in_n;
   wmf_pkg::pixel_type prefix_in_n;

   wmf_pkg::cell_ctl_type          ctl_ff;
   wmf_pkg::pixel_type [CELLS-1:0] vals_ff;
   logic [CELLS-1:0]               mask_ff;
   logic [RANK_W-1:0]              rank_ff;
   wmf_pkg::pixel_type             prefix_ff;

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         zeros[i] = mask_in[i] & ~vals_in[i][BIT];
      end
      cnt      = CNT_W'($countones(zeros));
      take_one = CNT_W'(rank_in) >= cnt;
      // keep the candidates on the side that holds the rank
      mask_in_n   = take_one ? (mask_in & ~zeros) : zeros;
      rank_in_n   = take_one ? RANK_W'(CNT_W'(rank_in) - cnt) : rank_in;
      prefix_in_n = prefix_in;
      prefix_in_n[BIT] = take_one;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vals_ff   <= vals_in;
         mask_ff   <= mask_in_n;
         rank_ff   <= rank_in_n;
         prefix_ff <= prefix_in_n;
      end
   end

   assign ctl_out    = ctl_ff;
   assign vals_out   = vals_ff;
   assign mask_out   = mask_ff;
   assign rank_out   = rank_ff;
   assign prefix_out = prefix_ff;

   // edge pixels may carry rows not yet written, so only interior ones are checked
   a_rank_in_set : assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.valid && ctl_ff.interior) |->
         (CNT_W'(rank_ff) < CNT_W'($countones(mask_ff))))
      else $error("rank left the candidate set");

endmodule

// ===== hdl/window_median_filter_core.sv =====
// Top level of the streaming 2-D median filter: CSRs, counters, window, median chain.
// Depends on wmf_pkg, wmf_row_store and wmf_bit_cell.
//
//   channel  | handshake               | payload
//   req      | req_valid / req_ready   | req_command, req_pixel_in
//   rsp      | rsp_valid / rsp_ready   | rsp_pixel_out, rsp_last_pixel
//   csr      | csr_psel/penable/pready | csr_paddr, csr_pwrite, csr_pwdata, csr_prdata
//
// One item per cycle while rsp is not stalled; each result travels from its causing
// transfer through the line store read, window shift, eight bit cells of the median
// chain and output register. The whole pipeline advances as one whenever the output
// register is empty or being taken, so req_ready drops only while rsp stalls.
// Synchronous reset clears control state; line stores are not cleared.
module window_median_filter_core #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_RADIUS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_last_pixel,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SIDE   = 2 * MAX_RADIUS + 1;
   localparam int CELLS  = SIDE * SIDE;
   localparam int LINES  = 2 * MAX_RADIUS;
   localparam int LINE_W = $clog2(LINES);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = (COL_W + 1 > 10) ? COL_W + 1 : 10;
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int RANK_W = $clog2(CELLS);
   localparam int SIDE_W = $clog2(SIDE);
   localparam int STAGES = wmf_pkg::PIX_W;
   localparam int ROW_W  = wmf_pkg::ROW_W;
   localparam int OROW_W = wmf_pkg::OROW_W;

   // ---------------- configuration registers ----------------
   logic [9:0]  width_ff;
   logic [11:0] height_ff;
   logic [1:0]  radius_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wmf_pkg::WIDTH_RESET;
         height_ff <= wmf_pkg::HEIGHT_RESET;
         radius_ff <= wmf_pkg::RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            wmf_pkg::REG_FRAME_WIDTH:   width_ff  <= csr_pwdata[9:0];
            wmf_pkg::REG_FRAME_HEIGHT:  height_ff <= csr_pwdata[11:0];
            wmf_pkg::REG_KERNEL_RADIUS: radius_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         wmf_pkg::REG_FRAME_WIDTH:   csr_prdata = {22'd0, width_ff};
         wmf_pkg::REG_FRAME_HEIGHT:  csr_prdata = {20'd0, height_ff};
         wmf_pkg::REG_KERNEL_RADIUS: csr_prdata = {30'd0, radius_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // clamp configuration into its working range
   logic [WID_W-1:0]  w_eff;
   logic [11:0]       h_eff;
   logic [2:0]        r3;
   logic [RAD_W-1:0]  r_eff;
   logic [LINE_W:0]   n2;

   always_comb begin
      w_eff = WID_W'(width_ff);
      if (width_ff < 10'(wmf_pkg::WIDTH_MIN)) begin
         w_eff = WID_W'(wmf_pkg::WIDTH_MIN);
      end else if (WID_W'(width_ff) > WID_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end
      h_eff = (height_ff < 12'(wmf_pkg::HEIGHT_MIN)) ? 12'(wmf_pkg::HEIGHT_MIN) : height_ff;
      r3 = {1'b0, radius_ff};
      if (radius_ff == 2'd0) begin
         r3 = 3'd1;
      end else if (r3 > 3'(MAX_RADIUS)) begin
         r3 = 3'(MAX_RADIUS);
      end
      r_eff = RAD_W'(r3);
      n2    = (LINE_W + 1)'({r_eff, 1'b0});
   end

   // ---------------- input side: position counters ----------------
   logic                advance;
   logic                req_fire;
   wmf_pkg::pixel_type  val;

   logic [COL_W-1:0]   col_ff,  col_in;
   logic [ROW_W-1:0]   row_ff,  row_in;
   logic [LINE_W-1:0]  slot_ff, slot_in;
   logic [OROW_W-1:0]  orow_ff, orow_in;
   logic [COL_W-1:0]   ocol_ff, ocol_in;

   logic               emit;
   logic               interior;
   logic               last;
   logic [WID_W-1:0]   col_nx;
   logic [WID_W-1:0]   ocol_nx;

   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && req_ready;
   assign val       = req_command ? '0 : req_pixel_in;

   always_comb begin
      emit = (row_ff > ROW_W'(r_eff)) ||
             ((row_ff == ROW_W'(r_eff)) && (WID_W'(col_ff) >= WID_W'(r_eff)));
      interior = (orow_ff >= OROW_W'(r_eff)) &&
                 ((13'(orow_ff) + 13'(r_eff)) < 13'(h_eff)) &&
                 (WID_W'(ocol_ff) >= WID_W'(r_eff)) &&
                 ((WID_W'(ocol_ff) + WID_W'(r_eff)) < w_eff);
      col_nx  = WID_W'(col_ff) + WID_W'(1);
      ocol_nx = WID_W'(ocol_ff) + WID_W'(1);
      last    = ((orow_ff >= h_eff - 12'd1) && (ocol_nx >= w_eff)) || (orow_ff >= h_eff);

      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (req_fire) begin
         if (col_nx >= w_eff) begin
            col_in = '0;
            if (row_ff != '1) begin
               row_in  = row_ff + ROW_W'(1);
               slot_in = ((LINE_W + 1)'(slot_ff) + (LINE_W + 1)'(1) >= n2) ?
                         '0 : slot_ff + LINE_W'(1);
            end
         end else begin
            col_in = COL_W'(col_nx);
         end
         if (emit) begin
            if (last) begin
               // frame done: restart all positions
               col_in  = '0;
               row_in  = '0;
               slot_in = '0;
               orow_in = '0;
               ocol_in = '0;
            end else if (ocol_nx >= w_eff) begin
               ocol_in = '0;
               orow_in = orow_ff + OROW_W'(1);
            end else begin
               ocol_in = COL_W'(ocol_nx);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

   // ---------------- stage A: line store read ----------------
   wmf_pkg::pixel_type [LINES-1:0] line_data;

   wmf_row_store #(
      .LINES  (LINES),
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W),
      .LINE_W (LINE_W)
   ) u_row_store (
      .clock   (clock),
      .access  (req_fire),
      .wr_line (slot_ff),
      .addr    (col_ff),
      .wr_data (val),
      .rd_data (line_data)
   );

   logic               a_valid_ff;
   wmf_pkg::pixel_type a_val_ff;
   logic [LINE_W-1:0]  a_slot_ff;
   logic [RAD_W-1:0]   a_r_ff;
   logic               a_emit_ff;
   logic               a_last_ff;
   logic               a_interior_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_val_ff      <= val;
         a_slot_ff     <= slot_ff;
         a_r_ff        <= r_eff;
         a_emit_ff     <= emit;
         a_last_ff     <= last;
         a_interior_ff <= interior;
      end
   end

   // ---------------- stage B: window shift ----------------
   logic [LINE_W:0]                        a_n2;
   logic [LINE_W:0]                        idx;
   wmf_pkg::pixel_type [SIDE-1:0]          colv;
   wmf_pkg::pixel_type [SIDE-1:0][SIDE-1:0] win_ff, win_in;

   always_comb begin
      a_n2 = (LINE_W + 1)'({a_r_ff, 1'b0});
      for (int k = 0; k < SIDE; k++) begin
         // oldest buffered row first, newest pixel at row 2R
         idx = (LINE_W + 1)'(a_slot_ff) + (LINE_W + 1)'(k);
         if (idx >= a_n2) begin
            idx = idx - a_n2;
         end
         if ((LINE_W + 1)'(k) < a_n2) begin
            colv[k] = line_data[LINE_W'(idx)];
         end else if ((LINE_W + 1)'(k) == a_n2) begin
            colv[k] = a_val_ff;
         end else begin
            colv[k] = '0;
         end
      end
      for (int k = 0; k < SIDE; k++) begin
         win_in[k][0] = colv[k];
         for (int j = 1; j < SIDE; j++) begin
            win_in[k][j] = win_ff[k][j-1];
         end
      end
   end

   logic             b_valid_ff;
   logic             b_last_ff;
   logic             b_interior_ff;
   logic [RAD_W-1:0] b_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_last_ff     <= a_last_ff;
         b_interior_ff <= a_interior_ff;
         b_r_ff        <= a_r_ff;
         if (a_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   // ---------------- median chain ----------------
   wmf_pkg::cell_ctl_type          ctl_s    [STAGES+1];
   wmf_pkg::pixel_type [CELLS-1:0] vals_s   [STAGES+1];
   logic [CELLS-1:0]               mask_s   [STAGES+1];
   logic [RANK_W-1:0]              rank_s   [STAGES+1];
   wmf_pkg::pixel_type             prefix_s [STAGES+1];

   always_comb begin
      for (int k = 0; k < SIDE; k++) begin
         for (int j = 0; j < SIDE; j++) begin
            vals_s[0][k*SIDE + j] = win_ff[k][j];
            mask_s[0][k*SIDE + j] = (k <= 2 * int'(b_r_ff)) && (j <= 2 * int'(b_r_ff));
         end
      end
      rank_s[0]            = RANK_W'(2 * int'(b_r_ff) * (int'(b_r_ff) + 1));
      prefix_s[0]          = '0;
      ctl_s[0].valid       = b_valid_ff;
      ctl_s[0].last        = b_last_ff;
      ctl_s[0].interior    = b_interior_ff;
      ctl_s[0].center      = win_ff[SIDE_W'(b_r_ff)][SIDE_W'(b_r_ff)];
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      wmf_bit_cell #(
         .CELLS  (CELLS),
         .RANK_W (RANK_W),
         .BIT    (STAGES - 1 - g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .ctl_in     (ctl_s[g]),
         .vals_in    (vals_s[g]),
         .mask_in    (mask_s[g]),
         .rank_in    (rank_s[g]),
         .prefix_in  (prefix_s[g]),
         .ctl_out    (ctl_s[g+1]),
         .vals_out   (vals_s[g+1]),
         .mask_out   (mask_s[g+1]),
         .rank_out   (rank_s[g+1]),
         .prefix_out (prefix_s[g+1])
      );
   end

   // ---------------- output register ----------------
   wmf_pkg::pixel_type rsp_pixel_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_s[STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= ctl_s[STAGES].interior ? prefix_s[STAGES] : ctl_s[STAGES].center;
         rsp_last_ff  <= ctl_s[STAGES].last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_last_pixel = rsp_last_ff;

   // ---------------- checks ----------------
   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && last) |=>
         (col_ff == '0 && row_ff == '0 && orow_ff == '0 && ocol_ff == '0))
      else $error("counters not cleared after final pixel");

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      (LINE_W + 1)'(slot_ff) < (LINE_W + 1)'(LINES))
      else $error("line slot out of range");

   a_first_row_silent : assert property (@(posedge clock) disable iff (reset)
      (req_fire && row_ff == '0) |=> !(a_valid_ff && a_emit_ff))
      else $error("first row produced a result");

endmodule
